// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SDPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdps assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SDPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdps assertion failed");

`endif

// ===== hw/rtl/sdps_pkg.sv =====
`default_nettype none

package sdps_pkg;

    // item kinds on the input stream
    typedef enum logic [1:0] {
        MODE_BYTE   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_RESET  = 2'd3
    } sdps_mode_t;

    // result kinds on the output stream
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_INIT_BACKOFF = 2'd0;
    localparam logic [1:0] REG_MAX_BACKOFF  = 2'd1;
    localparam logic [1:0] REG_BROKER_PORT  = 2'd2;

    // configuration reset values
    localparam logic [31:0] INIT_BACKOFF_DEFAULT = 32'd1000;
    localparam logic [31:0] MAX_BACKOFF_DEFAULT  = 32'd300000;
    localparam logic [15:0] BROKER_PORT_DEFAULT  = 16'd1883;

    localparam int MAX_PACKET_BYTES_DEFAULT = 2048;

    // stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 120;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // packet parsing
    localparam int WIN_DEPTH    = 15;
    localparam int SVC_LEN      = 9;
    localparam int HDR_LEN      = 12;
    localparam int SVC_MIN_POS  = HDR_LEN + SVC_LEN;
    localparam int ADDR_MIN_POS = HDR_LEN + 14;
    localparam int FLAGS_POS    = 2;
    localparam int ANCOUNT_HI   = 6;
    localparam int ANCOUNT_LO   = 7;
    localparam int ARCOUNT_HI   = 10;
    localparam int ARCOUNT_LO   = 11;

    // advertised service name, byte by byte
    localparam logic [7:0] SVC_TEXT [SVC_LEN] = '{
        8'h5F, 8'h64, 8'h64, 8'h63, 8'h2D, 8'h6D, 8'h71, 8'h74, 8'h74
    };

    // end of packet verdict from the scanner
    typedef struct packed {
        logic        accept;
        logic [31:0] addr;
    } sdps_scan_t;

    // discovery state after one item
    typedef struct packed {
        logic        new_broker;
        logic        query_sent;
        logic        broker_valid;
        logic [31:0] broker_ip;
        logic [31:0] queries;
        logic [31:0] backoff;
    } sdps_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdps_scan.sv =====
`default_nettype none

module sdps_scan
    import sdps_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output sdps_scan_t      verdict
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [7:0]       win_reg [WIN_DEPTH];
    logic [7:0]       win_next [WIN_DEPTH];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             resp_reg;
    logic             resp_next;
    logic             count_reg;
    logic             count_next;
    logic             svc_reg;
    logic             svc_next;
    logic             addr_found_reg;
    logic             addr_found_next;
    logic [31:0]      addr_reg;
    logic [31:0]      addr_next;
    logic [31:0]      pos_ext;
    logic [31:0]      pos_next_ext;
    logic             in_range;
    logic             svc_match;
    logic             rr_match;

    assign pos_ext  = {{(32-POS_W){1'b0}}, pos_reg};
    assign in_range = pos_reg < POS_W'(MAX_PACKET_BYTES);

    // window after shifting in the new byte
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WIN_DEPTH-1] = data_byte;
    end

    // service name ending at the byte before the new one
    always_comb
    begin
        svc_match = 1'b1;
        for (int i = 0; i < SVC_LEN; i++)
        begin
            if (win_next[5 + i] != SVC_TEXT[i])
            begin
                svc_match = 1'b0;
            end
        end
    end

    // type A, class IN record at the window head
    assign rr_match = (win_next[0] == 8'h00) && (win_next[1] == 8'h01) &&
                      (win_next[2][6:0] == 7'h00) && (win_next[3] == 8'h01);

    // per-byte flag updates
    always_comb
    begin
        pos_next        = pos_reg;
        resp_next       = resp_reg;
        count_next      = count_reg;
        svc_next        = svc_reg;
        addr_found_next = addr_found_reg;
        addr_next       = addr_reg;
        if (in_range)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_ext == 32'(FLAGS_POS))
            begin
                resp_next = data_byte[7];
            end
            if ((pos_ext == 32'(ANCOUNT_HI) || pos_ext == 32'(ANCOUNT_LO) ||
                 pos_ext == 32'(ARCOUNT_HI) || pos_ext == 32'(ARCOUNT_LO)) &&
                (data_byte != 8'h00))
            begin
                count_next = 1'b1;
            end
            if ((pos_ext >= 32'(SVC_MIN_POS)) && svc_match)
            begin
                svc_next = 1'b1;
            end
            if ((pos_ext >= 32'(ADDR_MIN_POS)) && !addr_found_reg && rr_match)
            begin
                addr_found_next = 1'b1;
                addr_next = {win_next[10], win_next[11], win_next[12], win_next[13]};
            end
        end
    end

    assign pos_next_ext = {{(32-POS_W){1'b0}}, pos_next};

    // verdict on the packet as it stands after this byte
    assign verdict.accept = (pos_next_ext >= 32'(HDR_LEN)) && resp_next && count_next &&
                            svc_next && addr_found_next;
    assign verdict.addr   = addr_next;

    // byte window
    always_ff @(posedge clk)
    begin
        if (byte_en && in_range)
        begin
            win_reg <= win_next;
        end
    end

    // packet scan state, cleared at the end of every packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            resp_reg       <= 1'b0;
            count_reg      <= 1'b0;
            svc_reg        <= 1'b0;
            addr_found_reg <= 1'b0;
            addr_reg       <= '0;
        end
        else if (byte_en)
        begin
            if (last_byte)
            begin
                pos_reg        <= '0;
                resp_reg       <= 1'b0;
                count_reg      <= 1'b0;
                svc_reg        <= 1'b0;
                addr_found_reg <= 1'b0;
                addr_reg       <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                resp_reg       <= resp_next;
                count_reg      <= count_next;
                svc_reg        <= svc_next;
                addr_found_reg <= addr_found_next;
                addr_reg       <= addr_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdps_backoff.sv =====
`default_nettype none

module sdps_backoff
    import sdps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_en,
    input  wire sdps_mode_t  mode,
    input  wire logic        last_byte,
    input  wire logic [31:0] now_ms,
    input  wire sdps_scan_t  verdict,
    input  wire logic [31:0] initial_backoff_ms,
    input  wire logic [31:0] max_backoff_ms,
    output sdps_status_t     status
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] ip_reg;
    logic [31:0] ip_next;
    logic [31:0] backoff_reg;
    logic [31:0] backoff_next;
    logic [31:0] last_query_reg;
    logic [31:0] last_query_next;
    logic [31:0] queries_reg;
    logic [31:0] queries_next;
    logic [31:0] elapsed;
    logic [32:0] doubled;
    logic [31:0] capped;
    logic        tick_fire;
    logic        pkt_accept;

    // backoff doubling in 33 bits, then clamped
    assign elapsed   = now_ms - last_query_reg;
    assign doubled   = {backoff_reg, 1'b0};
    assign capped    = (doubled > {1'b0, max_backoff_ms}) ? max_backoff_ms : doubled[31:0];
    assign tick_fire = (mode == MODE_TICK) && !valid_reg && (elapsed >= backoff_reg);
    assign pkt_accept = (mode == MODE_BYTE) && last_byte && verdict.accept;

    // next discovery state by item kind
    always_comb
    begin
        valid_next      = valid_reg;
        ip_next         = ip_reg;
        backoff_next    = backoff_reg;
        last_query_next = last_query_reg;
        queries_next    = queries_reg;
        unique case (mode)
            MODE_BYTE:
            begin
                if (pkt_accept)
                begin
                    valid_next   = 1'b1;
                    ip_next      = verdict.addr;
                    backoff_next = initial_backoff_ms;
                    queries_next = '0;
                end
            end
            MODE_TICK:
            begin
                if (tick_fire)
                begin
                    queries_next    = queries_reg + 32'd1;
                    last_query_next = now_ms;
                    backoff_next    = capped;
                end
            end
            MODE_REMOVE:
            begin
                valid_next   = 1'b0;
                backoff_next = initial_backoff_ms;
            end
            MODE_RESET:
            begin
                backoff_next = initial_backoff_ms;
                queries_next = '0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    assign status.new_broker   = pkt_accept;
    assign status.query_sent   = tick_fire;
    assign status.broker_valid = valid_next;
    assign status.broker_ip    = ip_next;
    assign status.queries      = queries_next;
    assign status.backoff      = backoff_next;

    // discovery and backoff state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            ip_reg         <= '0;
            backoff_reg    <= INIT_BACKOFF_DEFAULT;
            last_query_reg <= '0;
            queries_reg    <= '0;
        end
        else if (item_en)
        begin
            valid_reg      <= valid_next;
            ip_reg         <= ip_next;
            backoff_reg    <= backoff_next;
            last_query_reg <= last_query_next;
            queries_reg    <= queries_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/service_discovery_packet_scanner.sv =====
`default_nettype none

// Scans service discovery response payloads arriving one byte per transfer and
// tracks a discovered broker, plus an exponential query backoff driven by tick
// transfers. The block takes one input transfer every clock cycle when the
// output side keeps up; a result is driven from the result register, and all
// per-item work sits between the input register and the result register. A
// result waiting on the output side holds back the next input item, whether
// or not that item gives a result. A packet byte without tlast, a removal and
// a backoff reset give no result; the last byte of a packet and a tick each
// give exactly one. Configuration writes are always ready and are meant to be
// issued while no item is in flight.

module service_discovery_packet_scanner
    import sdps_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte, now_ms
    input  wire logic                   s_axis_tlast,
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // mode
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // new_broker, query_sent,
                                                       // broker_valid, broker_ip,
                                                       // broker_port, queries_so_far,
                                                       // next_backoff_ms, zero pad
    output logic                        m_axis_tuser,  // result_kind
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PAD_W = OUT_TDATA_W - 115;

    logic         in_valid_reg;
    sdps_mode_t   in_mode_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic [31:0]  in_now_reg;
    logic         out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic         out_kind_reg;
    logic [31:0]  init_backoff_reg;
    logic [31:0]  max_backoff_reg;
    logic [15:0]  port_reg;
    logic         advance;
    logic         process;
    logic         has_result;
    logic         byte_en;
    sdps_scan_t   verdict;
    sdps_status_t status;

    // stage control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign byte_en       = process && (in_mode_reg == MODE_BYTE);
    assign has_result    = ((in_mode_reg == MODE_BYTE) && in_last_reg) ||
                           (in_mode_reg == MODE_TICK);
    assign cfg_ready     = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg <= sdps_mode_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata[7:0];
            in_last_reg <= s_axis_tlast;
            in_now_reg  <= s_axis_tdata[39:8];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_backoff_reg <= INIT_BACKOFF_DEFAULT;
            max_backoff_reg  <= MAX_BACKOFF_DEFAULT;
            port_reg         <= BROKER_PORT_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INIT_BACKOFF: init_backoff_reg <= cfg_data;
                REG_MAX_BACKOFF:  max_backoff_reg  <= cfg_data;
                REG_BROKER_PORT:  port_reg         <= cfg_data[15:0];
                default:          port_reg         <= port_reg;
            endcase
        end
    end

    sdps_scan #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .verdict   (verdict)
    );

    sdps_backoff u_backoff (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_en            (process),
        .mode               (in_mode_reg),
        .last_byte          (in_last_reg),
        .now_ms             (in_now_reg),
        .verdict            (verdict),
        .initial_backoff_ms (init_backoff_reg),
        .max_backoff_ms     (max_backoff_reg),
        .status             (status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && has_result)
        begin
            out_kind_reg <= (in_mode_reg == MODE_TICK) ? KIND_TICK : KIND_PACKET;
            out_data_reg <= {{PAD_W{1'b0}}, status.backoff, status.queries, port_reg,
                             status.broker_ip, status.broker_valid, status.query_sent,
                             status.new_broker};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sdps_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module sdps_checker
    import sdps_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    logic        new_broker;
    logic        query_sent;
    logic        broker_valid;
    logic [31:0] queries;

    assign new_broker   = m_axis_tdata[0];
    assign query_sent   = m_axis_tdata[1];
    assign broker_valid = m_axis_tdata[2];
    assign queries      = m_axis_tdata[82:51];

    // a stalled result holds
    `SDPS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a discovery leaves the broker known with the query count cleared
    `SDPS_ASSERT_SAME(a_new_broker_state, clk, rst_n, m_axis_tvalid && new_broker, broker_valid && (queries == 32'd0))

    // a query only goes out while no broker is known
    `SDPS_ASSERT_SAME(a_query_no_broker, clk, rst_n, m_axis_tvalid && query_sent, !broker_valid)

    // packet reports never send queries, tick reports never discover
    `SDPS_ASSERT_SAME(a_kind_flags, clk, rst_n, m_axis_tvalid, (m_axis_tuser == KIND_TICK) ? !new_broker : !query_sent)

endmodule

bind service_discovery_packet_scanner sdps_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
